>>> design/oal_pkg.sv
// shared operation codes and beat payload types for the ordered array list
package oal_pkg;

    // operation codes carried in the mode field
    localparam logic [2:0] MODE_LOCATE = 3'd0;
    localparam logic [2:0] MODE_GET    = 3'd1;
    localparam logic [2:0] MODE_INSERT = 3'd2;
    localparam logic [2:0] MODE_DELETE = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;

    // request beat
    typedef struct packed {
        logic [2:0]         mode;
        logic [7:0]         position_in;
        logic signed [31:0] value_in;
    } req_t;

    // response beat
    typedef struct packed {
        logic               ok;
        logic signed [31:0] value_out;
        logic [6:0]         found_position;
        logic [7:0]         length_out;
        logic               is_empty;
    } rsp_t;

endpackage

>>> design/oal_stream_if.sv
// valid/ready stream channel carrying one payload per beat
interface oal_stream_if #(
    parameter type T = logic
) ();

    logic valid;
    logic ready;
    T     payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

>>> design/oal_ram.sv
// generic single write port, single read port ram with registered read data
module oal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> design/ordered_array_list.sv
// ordered array list: positional list of signed words in one ram, run by a small sequencer
//
//   channel   role     beat contents
//   -------   ------   ------------------------------------------------------
//   req       sink     mode, position_in, value_in
//   rsp       source   ok, value_out, found_position, length_out, is_empty
//
// one request at a time; req.ready is high only while the sequencer is idle.
// the single ram port pair sets the rate: one entry read and one written per cycle.
// reset clears the length and the control state but not the ram; the ram needs no clearing pass.
// a held response does not stall the next request until its result is ready.
module ordered_array_list #(
    parameter int CAPACITY = 128
) (
    input  logic          clk,
    input  logic          rst_n,
    oal_stream_if.sink    req,
    oal_stream_if.source  rsp
);

    import oal_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = (LW > 8) ? LW : 8;
    localparam logic [LW-1:0] CAP_LW = LW'(CAPACITY);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOC  = 3'd1;
    localparam logic [2:0] S_GET  = 3'd2;
    localparam logic [2:0] S_INS  = 3'd3;
    localparam logic [2:0] S_DEL  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic [LW-1:0] pos_reg, pos_next;
    logic [31:0]   val_reg, val_next;
    logic          rd_pend_reg, rd_pend_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic          res_ok_reg, res_ok_next;
    logic [31:0]   res_val_reg, res_val_next;
    logic [AW-1:0] res_pos_reg, res_pos_next;
    logic          out_valid_reg, out_valid_next;
    rsp_t          out_data_reg, out_data_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    logic [CW-1:0] pos_ext;
    logic [CW-1:0] len_ext;

    oal_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // handshake outputs
    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_data_reg;

    // range checks at a common width
    assign pos_ext = CW'(req.payload.position_in);
    assign len_ext = CW'(len_reg);

    // sequencer and ram control
    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        rd_pend_next   = rd_pend_reg;
        rd_idx_next    = rd_idx_reg;
        res_ok_next    = res_ok_reg;
        res_val_next   = res_val_reg;
        res_pos_next   = res_pos_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = rd_idx_reg;
        ram_wdata      = ram_rdata;
        ram_raddr      = AW'(idx_reg);

        // response beat taken
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    // rejected requests report failure with zero fields
                    res_ok_next  = 1'b0;
                    res_val_next = '0;
                    res_pos_next = '0;
                    rd_pend_next = 1'b0;
                    state_next   = S_FIN;
                    case (req.payload.mode)
                        MODE_LOCATE:
                        begin
                            val_next   = req.payload.value_in;
                            idx_next   = '0;
                            state_next = S_LOC;
                        end
                        MODE_GET:
                        begin
                            if (pos_ext < len_ext)
                            begin
                                ram_raddr  = AW'(pos_ext);
                                state_next = S_GET;
                            end
                        end
                        MODE_INSERT:
                        begin
                            if (pos_ext <= len_ext && len_reg != CAP_LW)
                            begin
                                idx_next   = len_reg;
                                pos_next   = LW'(pos_ext);
                                val_next   = req.payload.value_in;
                                state_next = S_INS;
                            end
                        end
                        MODE_DELETE:
                        begin
                            if (pos_ext < len_ext)
                            begin
                                idx_next   = LW'(pos_ext);
                                pos_next   = LW'(pos_ext);
                                state_next = S_DEL;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            len_next    = '0;
                            res_ok_next = 1'b1;
                        end
                        default:
                        begin
                            res_ok_next = 1'b0;
                        end
                    endcase
                end
            end

            // pipelined scan: compare last read while issuing the next one
            S_LOC:
            begin
                rd_pend_next = 1'b0;
                if (rd_pend_reg && ram_rdata == val_reg)
                begin
                    res_ok_next  = 1'b1;
                    res_pos_next = rd_idx_reg;
                    state_next   = S_FIN;
                end
                else if (idx_reg < len_reg)
                begin
                    ram_raddr    = AW'(idx_reg);
                    rd_pend_next = 1'b1;
                    rd_idx_next  = AW'(idx_reg);
                    idx_next     = idx_reg + LW'(1);
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            // read data is registered and arrives in the cycle after the address
            S_GET:
            begin
                res_ok_next  = 1'b1;
                res_val_next = ram_rdata;
                state_next   = S_FIN;
            end

            // shift up from the top, then drop the new value in place
            S_INS:
            begin
                rd_pend_next = 1'b0;
                if (rd_pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = rd_idx_reg + AW'(1);
                    ram_wdata = ram_rdata;
                end
                else if (idx_reg == pos_reg)
                begin
                    ram_we      = 1'b1;
                    ram_waddr   = AW'(pos_reg);
                    ram_wdata   = val_reg;
                    len_next    = len_reg + LW'(1);
                    res_ok_next = 1'b1;
                    state_next  = S_FIN;
                end
                if (idx_reg > pos_reg)
                begin
                    ram_raddr    = AW'(idx_reg - LW'(1));
                    rd_pend_next = 1'b1;
                    rd_idx_next  = AW'(idx_reg - LW'(1));
                    idx_next     = idx_reg - LW'(1);
                end
            end

            // first read is the removed entry, later reads move down one place
            S_DEL:
            begin
                rd_pend_next = 1'b0;
                if (rd_pend_reg)
                begin
                    if (rd_idx_reg == AW'(pos_reg))
                    begin
                        res_val_next = ram_rdata;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = rd_idx_reg - AW'(1);
                        ram_wdata = ram_rdata;
                    end
                end
                if (idx_reg < len_reg)
                begin
                    ram_raddr    = AW'(idx_reg);
                    rd_pend_next = 1'b1;
                    rd_idx_next  = AW'(idx_reg);
                    idx_next     = idx_reg + LW'(1);
                end
                else if (!rd_pend_reg)
                begin
                    len_next    = len_reg - LW'(1);
                    res_ok_next = 1'b1;
                    state_next  = S_FIN;
                end
            end

            // move the result into the output register once it is free
            S_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.ok             = res_ok_reg;
                    out_data_next.value_out      = res_val_reg;
                    out_data_next.found_position = 7'(res_pos_reg);
                    out_data_next.length_out     = 8'(len_reg);
                    out_data_next.is_empty       = (len_reg == '0);
                    state_next                   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            idx_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            idx_reg       <= idx_next;
            rd_pend_reg   <= rd_pend_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        val_reg      <= val_next;
        res_ok_reg   <= res_ok_next;
        res_val_reg  <= res_val_next;
        res_pos_reg  <= res_pos_next;
        out_data_reg <= out_data_next;
    end

endmodule
